>>> src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and datapath commands of the first-fit heap
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

	localparam int MAX_GRANULES = 1024;
	localparam int ADDR_W       = $clog2(MAX_GRANULES);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int CFG_W        = 11;
	localparam int REQ_W        = 15;
	localparam int GRAN_SHIFT   = 5;
	localparam int NEED_W       = REQ_W - GRAN_SHIFT + 1;
	localparam int MAXB_W       = 15;
	localparam int ARENA_RESET  = 625;

	localparam logic [1:0] ST_GRANTED = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FREED   = 2'd2;
	localparam logic [1:0] ST_REPORT  = 2'd3;

	typedef struct packed {
		logic              valid;
		logic              free;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] prev;
	} hdr_t;

	typedef enum logic [3:0] {
		OP_IDLE  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_WRD   = 4'd2,
		OP_WCHK  = 4'd3,
		OP_SP1   = 4'd4,
		OP_SP2   = 4'd5,
		OP_GW    = 4'd6,
		OP_FRD   = 4'd7,
		OP_FCHK  = 4'd8,
		OP_FPCHK = 4'd9,
		OP_FNRD  = 4'd10,
		OP_FNCHK = 4'd11,
		OP_FNNWR = 4'd12,
		OP_FFIN  = 4'd13,
		OP_FIN   = 4'd14,
		OP_SWEEP = 4'd15
	} op_t;

	typedef struct packed {
		logic g_end;
		logic hit;
		logic split;
		logic c_bad;
		logic blk_bad;
		logic c_zero;
		logic nx_lt_n;
		logic nx_free;
		logic nn_lt_n;
		logic rpt;
		logic slot_free;
		logic sweep_last;
	} sts_t;

endpackage

`default_nettype wire

>>> src/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: header memory, block walk registers, merge/split arithmetic and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ffha_pkg::op_t                 cmd,
	input  wire logic                          cfg_we,
	input  wire logic [ffha_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                          func,
	input  wire logic [ffha_pkg::REQ_W-1:0]    request_bytes,
	input  wire logic [ffha_pkg::ADDR_W-1:0]   payload_granule,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic [1:0]                         status,
	output logic [ffha_pkg::ADDR_W-1:0]        granted_granule,
	output logic [ffha_pkg::MAXB_W-1:0]        max_free_bytes,
	output ffha_pkg::sts_t                     sts
);

	localparam int AW = ffha_pkg::ADDR_W;
	localparam int CW = ffha_pkg::CNT_W;

	ffha_pkg::hdr_t rd, cur_q, wdata;
	logic           we;
	logic [AW-1:0]  waddr, raddr;

	logic [ffha_pkg::CFG_W-1:0]  arena_q;
	logic [CW-1:0]               n;
	logic [CW-1:0]               g_q, ng_q, nx_q, nn_q, next_g, nn;
	logic [ffha_pkg::NEED_W-1:0] need_q;
	logic [AW-1:0]               c_q, pg_q, sw_q, best_q;
	logic                        rpt_q;
	logic [1:0]                  rst_q;
	logic                        out_valid_q;
	logic [1:0]                  status_q;
	logic [AW-1:0]               granted_q;
	logic [ffha_pkg::MAXB_W-1:0] maxb_q;
	logic                        slot_free;

	ffha_ram #(
		.WIDTH($bits(ffha_pkg::hdr_t)),
		.DEPTH(ffha_pkg::MAX_GRANULES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd)
	);

	// arena size saturated to the legal range
	always_comb begin
		if (int'(arena_q) < 2) begin
			n = CW'(2);
		end else if (int'(arena_q) > ffha_pkg::MAX_GRANULES) begin
			n = CW'(ffha_pkg::MAX_GRANULES);
		end else begin
			n = CW'(arena_q);
		end
	end

	assign next_g    = g_q + CW'(1) + CW'(rd.size);
	assign nn        = nx_q + CW'(1) + CW'(rd.size);
	assign slot_free = !out_valid_q || !out_stall;

	assign sts.g_end      = g_q >= n;
	assign sts.hit        = rd.free && (32'(rd.size) >= 32'(need_q));
	assign sts.split      = 32'(rd.size) > 32'(need_q);
	assign sts.c_bad      = (pg_q == '0) || ({1'b0, c_q} >= n);
	assign sts.blk_bad    = !rd.valid || rd.free;
	assign sts.c_zero     = c_q == '0;
	assign sts.nx_lt_n    = nx_q < n;
	assign sts.nx_free    = rd.free;
	assign sts.nn_lt_n    = nn < n;
	assign sts.rpt        = rpt_q;
	assign sts.slot_free  = slot_free;
	assign sts.sweep_last = sw_q == AW'(ffha_pkg::MAX_GRANULES - 1);

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (cmd)
			ffha_pkg::OP_WRD: begin
				raddr = g_q[AW-1:0];
			end
			ffha_pkg::OP_SP1: begin
				we    = 1'b1;
				waddr = ng_q[AW-1:0];
				wdata = '{valid: 1'b1, free: 1'b1,
					size: rd.size, prev: g_q[AW-1:0]};
				wdata.size = cur_q.size - AW'(need_q) - AW'(1);
				raddr = nx_q[AW-1:0];
			end
			ffha_pkg::OP_SP2: begin
				we    = nx_q < n;
				waddr = nx_q[AW-1:0];
				wdata = '{valid: rd.valid, free: rd.free,
					size: rd.size, prev: ng_q[AW-1:0]};
			end
			ffha_pkg::OP_GW: begin
				we    = 1'b1;
				waddr = g_q[AW-1:0];
				wdata = '{valid: 1'b1, free: 1'b0,
					size: AW'(need_q), prev: cur_q.prev};
			end
			ffha_pkg::OP_FRD: begin
				raddr = c_q;
			end
			ffha_pkg::OP_FCHK: begin
				raddr = rd.prev;
			end
			ffha_pkg::OP_FPCHK: begin
				we    = rd.free;
				waddr = c_q;
			end
			ffha_pkg::OP_FNRD: begin
				raddr = nx_q[AW-1:0];
			end
			ffha_pkg::OP_FNCHK: begin
				we    = 1'b1;
				waddr = nx_q[AW-1:0];
				raddr = nn[AW-1:0];
				if (!rd.free) begin
					wdata = '{valid: rd.valid, free: rd.free,
						size: rd.size, prev: c_q};
				end
			end
			ffha_pkg::OP_FNNWR: begin
				we    = 1'b1;
				waddr = nn_q[AW-1:0];
				wdata = '{valid: rd.valid, free: rd.free,
					size: rd.size, prev: c_q};
			end
			ffha_pkg::OP_FFIN: begin
				we    = 1'b1;
				waddr = c_q;
				wdata = '{valid: 1'b1, free: 1'b1,
					size: cur_q.size, prev: cur_q.prev};
			end
			ffha_pkg::OP_SWEEP: begin
				we    = 1'b1;
				waddr = sw_q;
				// entry 0 holds the single free block
				if (sw_q == '0) begin
					wdata = '{valid: 1'b1, free: 1'b1,
						size: AW'(n - CW'(1)), prev: '0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q     <= ffha_pkg::CFG_W'(ffha_pkg::ARENA_RESET);
			sw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				arena_q <= cfg_wdata;
			end
			if (cfg_we || cmd != ffha_pkg::OP_SWEEP) begin
				sw_q <= '0;
			end else begin
				sw_q <= sw_q + AW'(1);
			end
			if (cmd == ffha_pkg::OP_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			ffha_pkg::OP_LOAD: begin
				rpt_q  <= !func && (request_bytes == '0);
				need_q <= ffha_pkg::NEED_W'(({1'b0, request_bytes} + 16'd31)
					>> ffha_pkg::GRAN_SHIFT);
				pg_q   <= payload_granule;
				c_q    <= payload_granule - AW'(1);
				g_q    <= '0;
				best_q <= '0;
				rst_q  <= (!func && request_bytes == '0) ?
					ffha_pkg::ST_REPORT : ffha_pkg::ST_NOFIT;
			end
			ffha_pkg::OP_WCHK: begin
				cur_q <= rd;
				if (rpt_q) begin
					if (rd.free && rd.size > best_q) begin
						best_q <= rd.size;
					end
					g_q <= next_g;
				end else if (sts.hit) begin
					ng_q <= CW'(g_q + CW'(1) + CW'(need_q));
					nx_q <= next_g;
				end else begin
					g_q <= next_g;
				end
			end
			ffha_pkg::OP_GW: begin
				rst_q <= ffha_pkg::ST_GRANTED;
			end
			ffha_pkg::OP_FCHK: begin
				cur_q <= rd;
				nx_q  <= CW'(c_q) + CW'(1) + CW'(rd.size);
			end
			ffha_pkg::OP_FPCHK: begin
				// left neighbor free: it absorbs this block
				if (rd.free) begin
					c_q   <= cur_q.prev;
					cur_q <= '{valid: 1'b1, free: 1'b1,
						size: rd.size + cur_q.size + AW'(1), prev: rd.prev};
				end
			end
			ffha_pkg::OP_FNCHK: begin
				nn_q <= nn;
				if (rd.free) begin
					cur_q.size <= cur_q.size + rd.size + AW'(1);
				end
			end
			ffha_pkg::OP_FFIN: begin
				rst_q <= ffha_pkg::ST_FREED;
			end
			ffha_pkg::OP_FIN: begin
				if (slot_free) begin
					status_q  <= rst_q;
					granted_q <= (rst_q == ffha_pkg::ST_GRANTED) ?
						AW'(g_q + CW'(1)) : '0;
					maxb_q    <= rpt_q ?
						ffha_pkg::MAXB_W'({best_q, 5'b0}) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_granule = granted_q;
	assign max_free_bytes  = maxb_q;

endmodule

`default_nettype wire

>>> src/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences block walks, splits, merges and the clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           func,
	input  wire logic           cfg_we,
	input  wire ffha_pkg::sts_t sts,
	output ffha_pkg::op_t       cmd
);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_WRD   = 15'b000000000000010,
		S_WCHK  = 15'b000000000000100,
		S_SP1   = 15'b000000000001000,
		S_SP2   = 15'b000000000010000,
		S_GW    = 15'b000000000100000,
		S_FRD   = 15'b000000001000000,
		S_FCHK  = 15'b000000010000000,
		S_FPCHK = 15'b000000100000000,
		S_FNRD  = 15'b000001000000000,
		S_FNCHK = 15'b000010000000000,
		S_FNNWR = 15'b000100000000000,
		S_FFIN  = 15'b001000000000000,
		S_FIN   = 15'b010000000000000,
		S_SWEEP = 15'b100000000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   accept;

	assign in_stall = (state_q != S_IDLE) || cfg_we;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		cmd       = ffha_pkg::OP_IDLE;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd       = ffha_pkg::OP_LOAD;
					state_nxt = func ? S_FRD : S_WRD;
				end
			end
			S_WRD: begin
				cmd       = ffha_pkg::OP_WRD;
				state_nxt = sts.g_end ? S_FIN : S_WCHK;
			end
			S_WCHK: begin
				cmd = ffha_pkg::OP_WCHK;
				if (!sts.rpt && sts.hit) begin
					state_nxt = sts.split ? S_SP1 : S_GW;
				end else begin
					state_nxt = S_WRD;
				end
			end
			S_SP1: begin
				cmd       = ffha_pkg::OP_SP1;
				state_nxt = S_SP2;
			end
			S_SP2: begin
				cmd       = ffha_pkg::OP_SP2;
				state_nxt = S_GW;
			end
			S_GW: begin
				cmd       = ffha_pkg::OP_GW;
				state_nxt = S_FIN;
			end
			S_FRD: begin
				cmd       = ffha_pkg::OP_FRD;
				state_nxt = sts.c_bad ? S_FIN : S_FCHK;
			end
			S_FCHK: begin
				cmd = ffha_pkg::OP_FCHK;
				if (sts.blk_bad) begin
					state_nxt = S_FIN;
				end else begin
					state_nxt = sts.c_zero ? S_FNRD : S_FPCHK;
				end
			end
			S_FPCHK: begin
				cmd       = ffha_pkg::OP_FPCHK;
				state_nxt = S_FNRD;
			end
			S_FNRD: begin
				cmd       = ffha_pkg::OP_FNRD;
				state_nxt = sts.nx_lt_n ? S_FNCHK : S_FFIN;
			end
			S_FNCHK: begin
				cmd       = ffha_pkg::OP_FNCHK;
				state_nxt = (sts.nx_free && sts.nn_lt_n) ? S_FNNWR : S_FFIN;
			end
			S_FNNWR: begin
				cmd       = ffha_pkg::OP_FNNWR;
				state_nxt = S_FFIN;
			end
			S_FFIN: begin
				cmd       = ffha_pkg::OP_FFIN;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				cmd = ffha_pkg::OP_FIN;
				if (sts.slot_free) begin
					state_nxt = sts.rpt ? S_SWEEP : S_IDLE;
				end
			end
			S_SWEEP: begin
				cmd = ffha_pkg::OP_SWEEP;
				if (sts.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_SWEEP;
			end
		endcase
		// a register write rebuilds the arena
		if (cfg_we) begin
			state_nxt = S_SWEEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

>>> src/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with coalescing over an arena of 32-byte granules.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   in       | in_valid / in_stall | func, request_bytes, payload_granule
//   out      | out_valid/out_stall | status, granted_granule, max_free_bytes
//   cfg      | cfg_we              | cfg_wdata (arena size in granules)
//
// One item at a time. An allocate or report walks the block list through the
// header memory's single read port, a read state and a check state per block,
// then splits a fitting block; a free merges the block with free neighbours.
// After reset, after a register write and after each report, a clearing
// sweep writes all 1024 header entries with in_stall high.
// A waiting result holds the block in its final state until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ffha_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          func,
	input  wire logic [ffha_pkg::REQ_W-1:0]    request_bytes,
	input  wire logic [ffha_pkg::ADDR_W-1:0]   payload_granule,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic [ffha_pkg::ADDR_W-1:0]        granted_granule,
	output logic [ffha_pkg::MAXB_W-1:0]        max_free_bytes
);

	ffha_pkg::op_t  cmd;
	ffha_pkg::sts_t sts;

	ffha_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func    (func),
		.cfg_we  (cfg_we),
		.sts     (sts),
		.cmd     (cmd)
	);

	ffha_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.func           (func),
		.request_bytes  (request_bytes),
		.payload_granule(payload_granule),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.granted_granule(granted_granule),
		.max_free_bytes (max_free_bytes),
		.sts            (sts)
	);

endmodule

`default_nettype wire

>>> tb/first_fit_heap_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Self-checking bench for the first-fit heap allocator. A scoreboard class
// keeps its own header table, predicts each result as an item is accepted
// and checks results in order. Directed items come first, then random
// alloc/free/report traffic over several arena sizes and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
	logic [1:0]                      st;
	logic [ffha_pkg::ADDR_W-1:0]     gg;
	logic [ffha_pkg::MAXB_W-1:0]     mb;
} alloc_reply_t;

class heap_scoreboard;
	bit          hv[ffha_pkg::MAX_GRANULES];
	bit          hf[ffha_pkg::MAX_GRANULES];
	int unsigned hs[ffha_pkg::MAX_GRANULES];
	int unsigned hp[ffha_pkg::MAX_GRANULES];
	int unsigned arena_cfg;
	int unsigned live[$];
	alloc_reply_t pending[$];
	int errors;

	function new();
		errors = 0;
		arena_cfg = ffha_pkg::ARENA_RESET;
		clear_arena();
	endfunction

	function int unsigned span();
		if (arena_cfg < 2) return 2;
		if (arena_cfg > ffha_pkg::MAX_GRANULES) return ffha_pkg::MAX_GRANULES;
		return arena_cfg;
	endfunction

	function void clear_arena();
		for (int i = 0; i < ffha_pkg::MAX_GRANULES; i++) begin
			hv[i] = 0; hf[i] = 0; hs[i] = 0; hp[i] = 0;
		end
		hv[0] = 1;
		hf[0] = 1;
		hs[0] = span() - 1;
		live.delete();
	endfunction

	function void set_arena(int unsigned v);
		arena_cfg = v & 11'h7ff;
		clear_arena();
	endfunction

	function void note_input(bit f, int unsigned req, int unsigned pg);
		alloc_reply_t r;
		int unsigned n, g, need, ng, nx, nn, c, p, best;
		n = span();
		r.st = ffha_pkg::ST_NOFIT;
		r.gg = '0;
		r.mb = '0;
		if (!f && req == 0) begin
			best = 0;
			for (g = 0; g < n; g = g + 1 + hs[g])
				if (hf[g] && hs[g] > best) best = hs[g];
			r.mb = ffha_pkg::MAXB_W'(best * 32);
			r.st = ffha_pkg::ST_REPORT;
			clear_arena();
		end else if (!f) begin
			need = (req + 31) / 32;
			for (g = 0; g < n; g = g + 1 + hs[g]) begin
				if (!hf[g] || hs[g] < need) continue;
				if (hs[g] > need) begin
					ng = g + 1 + need;
					hv[ng] = 1;
					hf[ng] = 1;
					hs[ng] = hs[g] - need - 1;
					hp[ng] = g;
					nx = ng + 1 + hs[ng];
					if (nx < n) hp[nx] = ng;
					hs[g] = need;
				end
				hf[g] = 0;
				r.st = ffha_pkg::ST_GRANTED;
				r.gg = ffha_pkg::ADDR_W'(g + 1);
				live.push_back(g + 1);
				break;
			end
		end else begin
			c = pg - 1;
			if (pg >= 1 && c < n && hv[c] && !hf[c]) begin
				foreach (live[i])
					if (live[i] == pg) begin
						live.delete(i);
						break;
					end
				nx = c + 1 + hs[c];
				if (c != 0 && hf[hp[c]]) begin
					p = hp[c];
					hs[p] += hs[c] + 1;
					if (nx < n) hp[nx] = p;
					hv[c] = 0; hf[c] = 0; hs[c] = 0;
					c = p;
				end
				nx = c + 1 + hs[c];
				if (nx < n && hf[nx]) begin
					nn = nx + 1 + hs[nx];
					hs[c] += hs[nx] + 1;
					if (nn < n) hp[nn] = c;
					hv[nx] = 0; hf[nx] = 0; hs[nx] = 0;
				end
				hf[c] = 1;
				r.st = ffha_pkg::ST_FREED;
			end
		end
		pending.push_back(r);
	endfunction

	function void check_result(logic [1:0] st, logic [ffha_pkg::ADDR_W-1:0] gg,
			logic [ffha_pkg::MAXB_W-1:0] mb);
		alloc_reply_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result status %0d granule %0d bytes %0d",
				$time, st, gg, mb);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (st !== e.st) begin
			$display("%0t: status expected %0d actual %0d", $time, e.st, st);
			errors++;
		end
		if (gg !== e.gg) begin
			$display("%0t: granted_granule expected %0d actual %0d", $time, e.gg, gg);
			errors++;
		end
		if (mb !== e.mb) begin
			$display("%0t: max_free_bytes expected %0d actual %0d", $time, e.mb, mb);
			errors++;
		end
	endfunction
endclass

module first_fit_heap_allocator_tb;

	localparam longint CYCLE_LIMIT = 30000000;
	localparam int     ITEMS_PER_PHASE = 220;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	logic                         clk = 0;
	logic                         arst_n = 0;
	logic                         cfg_we = 0;
	logic [ffha_pkg::CFG_W-1:0]   cfg_wdata = '0;
	logic                         in_valid = 0;
	logic                         in_stall;
	logic                         func = 0;
	logic [ffha_pkg::REQ_W-1:0]   request_bytes = '0;
	logic [ffha_pkg::ADDR_W-1:0]  payload_granule = '0;
	logic                         out_valid;
	logic                         out_stall = 0;
	logic [1:0]                   status;
	logic [ffha_pkg::ADDR_W-1:0]  granted_granule;
	logic [ffha_pkg::MAXB_W-1:0]  max_free_bytes;

	heap_scoreboard sb = new();
	int     idle_mode = IDLE_NONE;
	longint cycles = 0;

	first_fit_heap_allocator u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.request_bytes   (request_bytes),
		.payload_granule (payload_granule),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.granted_granule (granted_granule),
		.max_free_bytes  (max_free_bytes)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECV: out_stall <= ($urandom_range(99) < 77);
			IDLE_BOTH: out_stall <= ($urandom_range(99) < 20);
			default:   out_stall <= 1'b0;
		endcase
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, granted_granule, max_free_bytes);
	end

	// holds the item until accepted; valid stays high for a following item
	task automatic send_item(bit f, int unsigned req, int unsigned pg);
		int pct;
		pct = (idle_mode == IDLE_SEND) ? 77 : (idle_mode == IDLE_BOTH) ? 20 : 0;
		while ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		func            <= f;
		request_bytes   <= ffha_pkg::REQ_W'(req);
		payload_granule <= ffha_pkg::ADDR_W'(pg);
		do @(posedge clk); while (in_stall);
		sb.note_input(f, req, pg);
	endtask

	// waits for the last result and for any clearing sweep to finish
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0 || in_stall) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_arena(int unsigned v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= ffha_pkg::CFG_W'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_arena(v);
	endtask

	task automatic random_item();
		int unsigned r, sz, k;
		r = $urandom_range(99);
		if (r < 2) begin
			send_item(0, 0, $urandom_range(1023));
		end else if (r < 45 || sb.live.size() == 0) begin
			k = $urandom_range(99);
			if (k < 80) sz = $urandom_range(160, 1);
			else if (k < 95) sz = $urandom_range(4000, 1);
			else sz = $urandom_range(32767);
			send_item(0, sz, $urandom_range(1023));
		end else if (r < 92) begin
			k = $urandom_range(sb.live.size() - 1);
			send_item(1, $urandom_range(32767), sb.live[k]);
		end else begin
			// stale, bogus or mid-block frees
			k = $urandom_range(2);
			if (k == 0) sz = $urandom_range(1023);
			else if (k == 1 && sb.live.size() != 0)
				sz = sb.live[$urandom_range(sb.live.size() - 1)] + 1;
			else sz = $urandom_range(8);
			send_item(1, $urandom_range(32767), sz);
		end
	endtask

	initial begin
		int unsigned a, b, c;
		int unsigned arenas[8] = '{625, 2, 0, 1024, 2047, 40, 1, 300};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: frees before any allocation, report, edge sizes
		send_item(1, 0, 1);
		send_item(1, 32767, 0);
		send_item(1, 0, 1023);
		send_item(0, 32767, 1023);
		send_item(0, 1, 0);
		a = 2;
		send_item(0, 64, 0);
		send_item(0, 64, 0);
		send_item(0, 64, 0);
		b = 4; c = 7;
		send_item(1, 0, b);
		send_item(1, 0, b);
		send_item(0, 33, 0);
		send_item(1, 0, b + 1);
		send_item(1, 0, a);
		send_item(1, 0, c);
		send_item(1, 0, b);
		send_item(0, 0, 0);
		// a request one granule smaller than the free block leaves an empty free remainder
		send_item(0, 19936, 0);
		send_item(0, 31, 0);
		send_item(0, 0, 1023);
		send_item(0, 19968, 0);
		send_item(0, 20000, 0);
		send_item(1, 0, 1);
		send_item(0, 0, 0);

		for (int ph = 0; ph < 8; ph++) begin
			write_arena(arenas[ph]);
			idle_mode = ph % 4;
			if (ph == 7) idle_mode = IDLE_NONE;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
			send_item(0, 0, 0);
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
